// File: rtl/fpdtf_pkg.sv
// shared types and constants for the fixed-point decimal text formatter
package fpdtf_pkg;

    localparam int VAL_W      = 32;
    localparam int DIG_W      = 4;
    localparam int NUM_DIGITS = 10;
    localparam int BCD_W      = NUM_DIGITS * DIG_W;
    localparam int STEP_W     = 5;
    localparam int IDX_W      = 4;
    localparam int CHAR_W     = 7;

    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(VAL_W - 1);

    localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;
    localparam logic [CHAR_W-1:0] CHAR_DOT   = 7'h2E;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;

    localparam logic [IDX_W-1:0] FRAC_DIGITS_TWO   = 4'd2;
    localparam logic [IDX_W-1:0] FRAC_DIGITS_THREE = 4'd3;

    typedef logic [NUM_DIGITS-1:0][DIG_W-1:0] bcd_t;

    typedef struct packed {
        logic neg;
        logic three;
        bcd_t digits;
    } fpdtf_job_t;

endpackage

// File: rtl/fpdtf_dabble.sv
// iterative shift-and-add-3 binary to bcd converter, one bit per cycle
module fpdtf_dabble (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [fpdtf_pkg::VAL_W-1:0] mag,
    output logic                      done,
    output fpdtf_pkg::bcd_t           bcd
);
    import fpdtf_pkg::*;

    logic [VAL_W-1:0]  bin_reg, bin_next;
    bcd_t              bcd_reg, bcd_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    bcd_t              adj;
    logic [BCD_W-1:0]  adj_flat;

    // add 3 to every digit of 5 or more before the shift
    always_comb begin
        for (int i = 0; i < NUM_DIGITS; i++) begin
            adj[i] = (bcd_reg[i] >= 4'd5) ? bcd_reg[i] + 4'd3 : bcd_reg[i];
        end
    end

    assign adj_flat = adj;

    always_comb begin
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            bin_next  = mag;
            bcd_next  = '0;
            step_next = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            bcd_next  = {adj_flat[BCD_W-2:0], bin_reg[VAL_W-1]};
            bin_next  = {bin_reg[VAL_W-2:0], 1'b0};
            step_next = step_reg + 1'b1;
            if (step_reg == LAST_STEP) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        bin_reg  <= bin_next;
        bcd_reg  <= bcd_next;
        step_reg <= step_next;
    end

    assign done = done_reg;
    assign bcd  = bcd_reg;

endmodule

// File: rtl/fpdtf_emit.sv
// character sequencer: optional sign, integer digits, point, fraction digits
module fpdtf_emit #(
    parameter int MAX_CHARS = 11
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  fpdtf_pkg::fpdtf_job_t       job,
    output logic                        busy,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [fpdtf_pkg::CHAR_W-1:0] text_char,
    output logic                        m_tlast
);
    import fpdtf_pkg::*;

    localparam int CNT_W = $clog2(MAX_CHARS + 1);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_CHARS - 1);

    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_SIGN = 3'd1;
    localparam logic [2:0] PH_INT  = 3'd2;
    localparam logic [2:0] PH_DOT  = 3'd3;
    localparam logic [2:0] PH_FRAC = 3'd4;

    fpdtf_job_t        job_reg, job_next;
    logic [2:0]        phase_reg, phase_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              valid_reg, valid_next;
    logic [CHAR_W-1:0] char_reg, char_next;
    logic              last_reg, last_next;

    logic [IDX_W-1:0]  fd_start, fd_cur, lead;
    logic [CHAR_W-1:0] digit_char;
    logic              load, final_char;

    assign fd_start = job.three ? FRAC_DIGITS_THREE : FRAC_DIGITS_TWO;
    assign fd_cur   = job_reg.three ? FRAC_DIGITS_THREE : FRAC_DIGITS_TWO;

    // highest nonzero integer digit, or the ones digit if all are zero
    always_comb begin
        lead = fd_start;
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if ((IDX_W'(i) > fd_start) && (job.digits[i] != '0)) begin
                lead = IDX_W'(i);
            end
        end
    end

    assign digit_char = CHAR_ZERO + {3'b000, job_reg.digits[idx_reg]};
    assign load       = (phase_reg != PH_IDLE) && (!valid_reg || m_tready);

    always_comb begin
        job_next   = job_reg;
        phase_next = phase_reg;
        idx_next   = idx_reg;
        cnt_next   = cnt_reg;
        valid_next = valid_reg;
        char_next  = char_reg;
        last_next  = last_reg;
        final_char = 1'b0;
        if (start) begin
            job_next   = job;
            phase_next = job.neg ? PH_SIGN : PH_INT;
            idx_next   = lead;
            cnt_next   = '0;
        end else if (load) begin
            unique case (phase_reg)
                PH_SIGN: begin
                    char_next  = CHAR_MINUS;
                    phase_next = PH_INT;
                end
                PH_INT: begin
                    char_next = digit_char;
                    if (idx_reg == fd_cur) begin
                        phase_next = PH_DOT;
                    end else begin
                        idx_next = idx_reg - 1'b1;
                    end
                end
                PH_DOT: begin
                    char_next  = CHAR_DOT;
                    phase_next = PH_FRAC;
                    idx_next   = fd_cur - 1'b1;
                end
                PH_FRAC: begin
                    char_next = digit_char;
                    if (idx_reg == '0) begin
                        final_char = 1'b1;
                    end else begin
                        idx_next = idx_reg - 1'b1;
                    end
                end
                default: begin
                    phase_next = PH_IDLE;
                end
            endcase
            last_next  = final_char || (cnt_reg == CNT_LAST);
            cnt_next   = cnt_reg + 1'b1;
            valid_next = 1'b1;
            if (last_next) begin
                phase_next = PH_IDLE;
            end
        end else if (valid_reg && m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            valid_reg <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            valid_reg <= valid_next;
        end
        job_reg  <= job_next;
        idx_reg  <= idx_next;
        cnt_reg  <= cnt_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign busy      = (phase_reg != PH_IDLE) || valid_reg;
    assign m_tvalid  = valid_reg;
    assign text_char = char_reg;
    assign m_tlast   = last_reg;

endmodule

// File: rtl/fixed_point_decimal_text_formatter.sv
// top level: fixed-point value to decimal ascii text, one character per transfer
// An item is taken when s_tready is high, which happens only while the block is
// idle. The magnitude goes through a 32-step shift-and-add-3 converter (one bit
// per cycle), then the characters leave one per cycle while m_tready is high:
// optional '-', integer digits without leading zeros, '.', and two or three
// fraction digits, cut after MAX_CHARS characters with tlast on the final one.
// Without back pressure the bit-serial converter takes up most of the time of one
// item; the text is at most MAX_CHARS characters long.
module fixed_point_decimal_text_formatter #(
    parameter int MAX_CHARS = 11
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] scaled_value
    input  logic [0:0]  s_tuser,   // [0] three_fraction_digits
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [6:0] text_char, [7] zero
    output logic        m_tlast
);
    import fpdtf_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic              neg_reg, neg_next;
    logic              three_reg, three_next;
    logic              accept, conv_done, emit_busy;
    logic [VAL_W-1:0]  mag;
    bcd_t              bcd;
    fpdtf_job_t        job;
    logic [CHAR_W-1:0] text_char;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    // the most negative value wraps to 2^31, which is what it should print
    assign mag      = s_tdata[VAL_W-1] ? (VAL_W'(0) - s_tdata) : s_tdata;

    always_comb begin
        state_next = state_reg;
        neg_next   = neg_reg;
        three_next = three_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    neg_next   = s_tdata[VAL_W-1];
                    three_next = s_tuser[0];
                    state_next = ST_CONV;
                end
            end
            ST_CONV: begin
                if (conv_done) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!emit_busy) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
        neg_reg   <= neg_next;
        three_reg <= three_next;
    end

    fpdtf_dabble u_dabble (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (accept),
        .mag     (mag),
        .done    (conv_done),
        .bcd     (bcd)
    );

    assign job = '{neg: neg_reg, three: three_reg, digits: bcd};

    fpdtf_emit #(
        .MAX_CHARS (MAX_CHARS)
    ) u_emit (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (conv_done && (state_reg == ST_CONV)),
        .job       (job),
        .busy      (emit_busy),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .text_char (text_char),
        .m_tlast   (m_tlast)
    );

    assign m_tdata = {1'b0, text_char};

endmodule

// File: rtl/fpdtf_checker.sv
// port-level checker for the formatter, bound to the top level
module fpdtf_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic        m_tlast
);

    // no new value is taken while text is still going out
    a_no_accept_while_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("input ready while a character is pending");

    // the conversion is running, so ready and output valid are both low right after an input transfer
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (!s_tready && !m_tvalid))
        else $error("block not busy after input transfer");

    // the final character closes the text; the next one needs a new conversion
    a_gap_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> !m_tvalid)
        else $error("character right after the last one");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("stalled output changed");

endmodule

bind fixed_point_decimal_text_formatter fpdtf_checker u_fpdtf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
